@@ hdl/sha_pkg.sv @@
// SHA-256 package: round constants, initial hash values, round functions,
// and the controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned LenPos     = 56;
    localparam logic [7:0]  PadByte    = 8'h80;

    typedef logic [31:0] t_word;

    // Round constant table
    function automatic t_word f_round_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    // Initial hash values H0..H7
    function automatic t_word f_init_h(input logic [2:0] idx);
        t_word h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic t_word f_rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Byte source for the block buffer write port
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } t_byte_src;

    // Controller to datapath commands
    typedef struct packed {
        logic       buf_we;      // write one byte into the block buffer
        t_byte_src  buf_src;
        logic [5:0] buf_addr;
        logic       cnt_inc;     // count one message byte
        logic       cnt_clr;
        logic       load_w;      // not read by the datapath; the schedule loads under rd_valid
        logic       comp_start;  // copy chaining value into working vars
        logic       round_en;    // one round
        logic       comp_add;    // fold working vars into chaining value
        logic       h_init;      // restore initial hash values
        logic       out_load;    // load digest word into output register
        logic [2:0] out_idx;
    } t_sha_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [5:0] pos;         // byte_count mod 64
    } t_sha_stat;

endpackage

@@ hdl/sha_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sha_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/sha_datapath.sv @@
// SHA-256 datapath: block buffer RAM, byte count, message schedule window,
// round logic, chaining value. Depends on sha_pkg and sha_ram.
`timescale 1ns / 1ps
module sha_datapath
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_sha_cmd   i_cmd,
    input  logic [7:0] i_data_byte,
    input  logic [5:0] i_rd_addr,
    input  logic       i_rd_valid,
    output t_sha_stat  o_stat,
    output t_word      o_digest_word
);
    logic [60:0] r_count;
    logic [7:0]  w_wdata;
    logic [7:0]  w_rdata;
    logic [63:0] w_bits;
    logic        r_rd_valid;
    t_word       r_w [16];
    t_word       r_v [8];
    t_word       r_h [8];
    logic [5:0]  r_round;
    t_word       w_wt, w_s0, w_s1, w_wnew, w_t1, w_t2;

    // Byte count; bit length is the count shifted by three
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.cnt_clr) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + 61'd1;
        end
    end
    assign w_bits      = {r_count, 3'b000};
    assign o_stat.pos  = r_count[5:0];

    // Write data select
    always_comb begin
        case (i_cmd.buf_src)
            SRC_DATA: w_wdata = i_data_byte;
            SRC_PAD:  w_wdata = PadByte;
            SRC_ZERO: w_wdata = 8'h00;
            default:  w_wdata = w_bits[8 * (7 - i_cmd.buf_addr[2:0]) +: 8];
        endcase
    end

    sha_ram #(.Width(8), .Depth(BlockBytes)) u_buf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.buf_we),
        .i_waddr (i_cmd.buf_addr),
        .i_wdata (w_wdata),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_rd_valid;
        end
    end

    // Schedule window: bytes shift in during load, words shift during rounds
    assign w_s0   = f_rotr(r_w[1], 7) ^ f_rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1   = f_rotr(r_w[14], 17) ^ f_rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_wnew = w_s1 + r_w[9] + w_s0 + r_w[0];
    assign w_wt   = r_w[0];

    // Read address runs one ahead of the arriving byte; words move down
    // when the first byte of the next word arrives
    always_ff @(posedge i_clk) begin
        if (r_rd_valid) begin
            r_w[15] <= {r_w[15][23:0], w_rdata};
            for (int i = 0; i < 15; i++) begin
                if (i_rd_addr[1:0] == 2'd1) begin
                    r_w[i] <= r_w[i + 1];
                end
            end
        end else if (i_cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_wnew;
        end
    end

    // Round function
    assign w_t1 = r_v[7]
        + (f_rotr(r_v[4], 6) ^ f_rotr(r_v[4], 11) ^ f_rotr(r_v[4], 25))
        + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + f_round_k(r_round) + w_wt;
    assign w_t2 = (f_rotr(r_v[0], 2) ^ f_rotr(r_v[0], 13) ^ f_rotr(r_v[0], 22))
        + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_start) begin
            r_v     <= r_h;
            r_round <= '0;
        end else if (i_cmd.round_en) begin
            r_v[7]  <= r_v[6];
            r_v[6]  <= r_v[5];
            r_v[5]  <= r_v[4];
            r_v[4]  <= r_v[3] + w_t1;
            r_v[3]  <= r_v[2];
            r_v[2]  <= r_v[1];
            r_v[1]  <= r_v[0];
            r_v[0]  <= w_t1 + w_t2;
            r_round <= r_round + 6'd1;
        end
    end

    // Chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.h_init) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= f_init_h(3'(i));
            end
        end else if (i_cmd.comp_add) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_digest_word <= r_h[i_cmd.out_idx];
        end
    end
endmodule

@@ hdl/sha_ctrl.sv @@
// SHA-256 controller: input handshake, padding sequencer, compression
// sequencing and digest output handshake. Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_ctrl
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_has_byte,
    input  logic       i_last,
    input  t_sha_stat  i_stat,
    output t_sha_cmd   o_cmd,
    output logic [5:0] o_rd_addr,
    output logic       o_rd_valid,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [2:0] o_word_index,
    output logic       o_last_word
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_LOAD  = 7'b0000100,
        ST_ROUND = 7'b0001000,
        ST_ADD   = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_WAIT  = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [6:0] r_cnt, n_cnt;        // load byte counter / round counter / first pad byte mark
    logic [5:0] r_pad, n_pad;        // pad write address
    logic       r_fin, n_fin;        // finishing a message
    logic       r_final, n_final;    // current block is the length block
    logic       r_padded, n_padded;  // 0x80 already written for this message
    logic [2:0] r_oidx, n_oidx;
    logic       r_ovalid, n_ovalid;
    logic       w_acc;

    assign o_ready      = (r_state == ST_IDLE);
    assign w_acc        = i_valid && o_ready;
    assign o_valid      = r_ovalid;
    assign o_word_index = r_oidx;
    assign o_last_word  = (r_oidx == 3'd7);
    assign o_rd_addr    = r_cnt[5:0];

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_pad      = r_pad;
        n_fin      = r_fin;
        n_final    = r_final;
        n_padded   = r_padded;
        n_oidx     = r_oidx;
        n_ovalid   = r_ovalid;
        o_cmd      = '0;
        o_cmd.buf_src = SRC_DATA;
        o_rd_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.buf_addr = i_stat.pos;
                if (w_acc) begin
                    n_fin    = i_last;
                    n_padded = 1'b0;
                    n_pad    = i_stat.pos + {5'd0, i_has_byte};
                    if (i_has_byte) begin
                        o_cmd.buf_we  = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end
                    if (i_has_byte && i_stat.pos == 6'd63) begin
                        n_final = 1'b0;
                        n_cnt   = '0;
                        n_state = ST_LOAD;
                    end else if (i_last) begin
                        n_state = ST_PAD;
                        n_pad   = i_stat.pos + {5'd0, i_has_byte};
                        n_cnt   = 7'd0;  // marks first pad byte
                    end
                end
            end
            // One buffer byte per cycle: 0x80, zeros, length
            ST_PAD: begin
                o_cmd.buf_we   = 1'b1;
                o_cmd.buf_addr = r_pad;
                if (r_cnt == 7'd0) begin
                    o_cmd.buf_src = SRC_PAD;
                end else if (r_final && r_pad >= 6'(LenPos)) begin
                    o_cmd.buf_src = SRC_LEN;
                end else begin
                    o_cmd.buf_src = SRC_ZERO;
                end
                n_cnt = 7'd1;
                n_pad = r_pad + 6'd1;
                if (r_cnt == 7'd0) begin
                    // room for the length after the pad byte?
                    n_final  = (r_pad < 6'(LenPos));
                    n_padded = 1'b1;
                end
                if (r_pad == 6'd63) begin
                    n_cnt   = '0;
                    n_state = ST_LOAD;
                end
            end
            // Stream 64 bytes from RAM into the schedule window
            ST_LOAD: begin
                o_rd_valid = (r_cnt != 7'd64);
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd64) begin
                    o_cmd.comp_start = 1'b1;
                    n_cnt   = '0;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                o_cmd.comp_add = 1'b1;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (!r_final) begin
                    // length goes in a second block; message that ended on
                    // a block boundary still needs its 0x80 at byte zero
                    n_final = 1'b1;
                    n_pad   = '0;
                    n_cnt   = r_padded ? 7'd1 : 7'd0;
                    n_state = ST_PAD;
                end else begin
                    n_oidx  = '0;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_idx  = r_oidx;
                n_ovalid = 1'b1;
                n_state  = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_ready) begin
                    n_ovalid = 1'b0;
                    if (r_oidx == 3'd7) begin
                        o_cmd.h_init  = 1'b1;
                        o_cmd.cnt_clr = 1'b1;
                        n_fin   = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_oidx  = r_oidx + 3'd1;
                        n_state = ST_OUT;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_fin    <= 1'b0;
            r_final  <= 1'b0;
            r_padded <= 1'b0;
            r_cnt    <= '0;
            r_pad    <= '0;
            r_oidx   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_fin    <= n_fin;
            r_final  <= n_final;
            r_padded <= n_padded;
            r_cnt    <= n_cnt;
            r_pad    <= n_pad;
            r_oidx   <= n_oidx;
        end
    end

`ifndef SYNTH
    // No input is taken while a digest word is pending
    a_no_accept_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input accepted during output");
    // Round count stays in range during rounds
    a_round_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_cnt < 7'd64)) else $error("round overrun");
    // Output only emitted for a finished message
    a_out_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_fin) else $error("digest without last");
    // Stalled digest word holds its index
    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_oidx)) else $error("index moved");
`endif
endmodule

@@ hdl/sha256_message_digest.sv @@
// SHA-256 message digest top level: joins controller and datapath.
// Depends on sha_pkg, sha_ctrl, sha_datapath.
//
// Usage: message bytes arrive one per item on the input channel
// (i_valid/o_ready) with i_has_byte and i_last. An item with i_last set
// ends the message; eight digest words then leave on the output channel
// (o_valid/i_ready), H0 first, o_last_word on the eighth.
// Flow: a byte that does not fill a block is taken without stalling. A
// byte that fills the block starts a compression: the 64-byte buffer
// memory streams into the schedule window through its one read port,
// the rounds run one per cycle, then the chaining add. Padding writes
// the buffer one byte per cycle, then runs one or two compressions.
// Each digest word is held while the receiver stalls; while words are
// pending no input is taken, so a stalled receiver holds the block.
// Reset (synchronous, active low) restores the initial hash values and
// clears the byte count; no clearing pass is needed.
`timescale 1ns / 1ps
module sha256_message_digest
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    t_sha_cmd   w_cmd;
    t_sha_stat  w_stat;
    logic [5:0] w_rd_addr;
    logic       w_rd_valid;

    sha_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_has_byte   (i_has_byte),
        .i_last       (i_last),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_rd_addr    (w_rd_addr),
        .o_rd_valid   (w_rd_valid),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word)
    );

    sha_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_data_byte   (i_data_byte),
        .i_rd_addr     (w_rd_addr),
        .i_rd_valid    (w_rd_valid),
        .o_stat        (w_stat),
        .o_digest_word (o_digest_word)
    );
endmodule

@@ bench/tb.sv @@
// Self-checking bench for sha256_message_digest: directed and random byte messages in,
// digest words out, checked against a SHA-256 predictor. Depends on sha_pkg.
`timescale 1ns / 1ps
module tb;
    import sha_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        lastw;
    } t_digest_item;

    // SHA-256 predictor plus queue of expected digest words
    class digest_board;
        logic [31:0]  hv[8];
        logic [7:0]   blk[64];
        logic [60:0]  nbytes;
        t_digest_item pending[$];
        int           n_err;
        int           n_words;
        int           n_msgs;

        function new();
            n_err   = 0;
            n_words = 0;
            n_msgs  = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) hv[i] = f_init_h(3'(i));
            nbytes = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w[64];
            logic [31:0] v[8];
            logic [31:0] t1, t2, s0, s1;
            for (int t = 0; t < 16; t++)
                w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
            for (int t = 16; t < 64; t++) begin
                s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = s1 + w[t-7] + s0 + w[t-16];
            end
            v = hv;
            for (int t = 0; t < 64; t++) begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + f_round_k(6'(t)) + w[t];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) hv[i] += v[i];
        endfunction

        // Note an accepted input item
        function void note_input(logic [7:0] b, logic hb, logic lst);
            int          p;
            logic [63:0] bits;
            t_digest_item d;
            if (hb) begin
                p = int'(nbytes[5:0]);
                blk[p] = b;
                nbytes = nbytes + 1'b1;
                if (p == 63) compress();
            end
            if (!lst) return;
            p = int'(nbytes[5:0]);
            blk[p] = PadByte;
            p++;
            if (p > LenPos) begin
                while (p < BlockBytes) blk[p++] = 8'h00;
                compress();
                p = 0;
            end
            while (p < LenPos) blk[p++] = 8'h00;
            bits = {nbytes, 3'b000};
            for (int k = 0; k < 8; k++) blk[LenPos + k] = bits[8*(7-k) +: 8];
            compress();
            for (int k = 0; k < 8; k++) begin
                d.word  = hv[k];
                d.idx   = 3'(k);
                d.lastw = (k == 7);
                pending.push_back(d);
            end
            n_msgs++;
            restart();
        endfunction

        // Check one accepted digest word
        function void check_word(logic [31:0] w, logic [2:0] ix, logic lw);
            t_digest_item d;
            n_words++;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected word %h idx %0d", w, ix);
                return;
            end
            d = pending.pop_front();
            if (d.word !== w || d.idx !== ix || d.lastw !== lw) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
                             d.word, d.idx, d.lastw, w, ix, lw);
            end
        endfunction
    endclass

    localparam int StallLimit = 20000;

    logic        i_clk, i_rst_n, i_valid, i_ready;
    logic [7:0]  i_data_byte;
    logic        i_has_byte, i_last;
    logic        o_ready, o_valid, o_last_word;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;

    digest_board board;
    int          idle_cycles;
    int          n_items;

    sha256_message_digest dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Accept monitors and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                board.note_input(i_data_byte, i_has_byte, i_last);
                n_items++;
            end
            if (o_valid && i_ready)
                board.check_word(o_digest_word, o_word_index, o_last_word);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= StallLimit) begin
                $display("timeout: no traffic for %0d cycles", StallLimit);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver stalls: modes change now and then, including no-stall stretches
    initial begin : rx_stall
        int mode;
        i_ready = 1'b0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 3) != 0);
                2: i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    int burst_left;

    // Send one item; bursts with random gaps between them
    task automatic send_item(input logic [7:0] b, input logic hb, input logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_has_byte  <= hb;
        i_last      <= lst;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_message(input int len, input bit ones);
        for (int i = 0; i < len; i++)
            send_item(ones ? 8'hff : 8'($urandom_range(0, 255)), 1'b1, 1'b0);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stim
        int len;
        board = new();
        idle_cycles = 0;
        n_items = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = 8'h00;
        i_has_byte = 1'b0;
        i_last = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, no-op item, "abc", byte with end,
        // all-ones and zero bytes, padding straddling a block (55/56 bytes), one full block (64)
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        wait_drained();
        send_message(54, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_message(55, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
        send_message(63, 1'b0);
        send_item(8'h01, 1'b1, 1'b1);
        wait_drained();

        // Random messages, mostly short, a few across block boundaries
        while (n_items < 470) begin
            case ($urandom_range(0, 9))
                0, 1:    len = $urandom_range(0, 3);
                2:       len = $urandom_range(60, 130);
                default: len = $urandom_range(4, 40);
            endcase
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 15) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            if ($urandom_range(0, 1)) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            else send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            if ($urandom_range(0, 7) == 0) wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("run covered %0d input items, %0d messages, %0d digest words",
                 n_items, board.n_msgs, board.n_words);
        if (board.n_err == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("errors %0d, words still expected %0d",
                     board.n_err, board.pending.size());
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
